@@ rtl/echo_subwords_round_unit_defines.svh @@
// Assertion macros shared by the checker
`ifndef ECHO_SUBWORDS_ROUND_UNIT_DEFINES_SVH
`define ECHO_SUBWORDS_ROUND_UNIT_DEFINES_SVH

`define ESR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

`define ESR_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

@@ rtl/esr_pkg.sv @@
package esr_pkg;

  typedef enum logic [1:0] {
    OP_PROCESS = 2'd0,
    OP_LOAD    = 2'd1,
    OP_READ    = 2'd2,
    OP_SPARE   = 2'd3
  } op_e;

  localparam int unsigned WordW = 128;

  typedef logic [WordW-1:0] word_t;

  // x * 2 in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

endpackage

@@ rtl/esr_aes_round.sv @@
// One AES encryption round: SubBytes, ShiftRows, MixColumns, AddRoundKey
module esr_aes_round (
  input  esr_pkg::word_t state_i,
  input  esr_pkg::word_t key_i,
  output esr_pkg::word_t state_o
);

  logic [7:0] sb [16];
  logic [7:0] a0, a1, a2, a3;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = esr_pkg::sbox(state_i[8*(r + 4*((c + r) % 4)) +: 8]);
      end
    end
    state_o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c];
      a1 = sb[4*c + 1];
      a2 = sb[4*c + 2];
      a3 = sb[4*c + 3];
      state_o[32*c +: 8]      = esr_pkg::xtime(a0) ^ esr_pkg::xtime(a1) ^ a1 ^ a2 ^ a3
                                ^ key_i[32*c +: 8];
      state_o[32*c + 8 +: 8]  = a0 ^ esr_pkg::xtime(a1) ^ esr_pkg::xtime(a2) ^ a2 ^ a3
                                ^ key_i[32*c + 8 +: 8];
      state_o[32*c + 16 +: 8] = a0 ^ a1 ^ esr_pkg::xtime(a2) ^ esr_pkg::xtime(a3) ^ a3
                                ^ key_i[32*c + 16 +: 8];
      state_o[32*c + 24 +: 8] = esr_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ esr_pkg::xtime(a3)
                                ^ key_i[32*c + 24 +: 8];
    end
  end

endmodule

@@ rtl/echo_subwords_round_unit.sv @@
// ECHO SubWords unit. Each transfer carries an operation and a 128-bit word: process runs
// the word through two AES rounds (first keyed by the running 128-bit counter, then a
// zero key) and steps the counter; load sets the counter; read (and the spare code)
// returns it. Load returns the new counter value. One item per cycle while the output is
// not held by m_axis_tready: an input register, both rounds as combinational logic, then a
// result register; an item moves from the input register into the result register when
// the result register is free or being drained. The counter resets to zero and wraps at 2^128.
module echo_subwords_round_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // operation[1:0], data_lo[65:2], data_hi[129:66]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // result_lo[63:0], result_hi[127:64]
);

  logic           in_vld_q;
  esr_pkg::op_e   op_q;
  esr_pkg::word_t data_q, ctr_q, ctr_d;
  logic           out_vld_q;
  esr_pkg::word_t res_q, res_d, r1, r2;
  logic           adv, take;

  // stage 1 moves when result register is free or being drained
  assign adv  = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign take = s_axis_tvalid && s_axis_tready;

  esr_aes_round u_round1 (.state_i(data_q), .key_i(ctr_q), .state_o(r1));
  esr_aes_round u_round2 (.state_i(r1), .key_i('0), .state_o(r2));

  always_comb begin
    ctr_d = ctr_q;
    res_d = ctr_q;
    case (op_q)
      esr_pkg::OP_PROCESS: begin
        res_d = r2;
        ctr_d = ctr_q + esr_pkg::word_t'(1);
      end
      esr_pkg::OP_LOAD: begin
        ctr_d = data_q;
        res_d = data_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctr_q     <= '0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) out_vld_q <= in_vld_q;
      if (in_vld_q && adv) ctr_q <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= esr_pkg::op_e'(s_axis_tdata[1:0]);
      data_q <= s_axis_tdata[129:2];
    end
    if (in_vld_q && adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

endmodule

@@ rtl/esr_checker.sv @@
`include "echo_subwords_round_unit_defines.svh"

module esr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  `ESR_ASSERT(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ESR_ASSERT(ready_when_drained, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `ESR_ASSERT(no_out_from_idle, clk_i, rst_ni, !$past(s_axis_tvalid, 2) && !$past(s_axis_tvalid) && !$past(m_axis_tvalid) |-> !m_axis_tvalid)
  `ESR_ASSERT_NORST(reset_clears, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind echo_subwords_round_unit esr_checker u_esr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
